>>> src/protobuf_wire_stream_parser_macros.svh
// Assertion helpers shared by the parser modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PROTOBUF_WIRE_STREAM_PARSER_MACROS_SVH
`define PROTOBUF_WIRE_STREAM_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pwsp_pkg.sv
package pwsp_pkg;

	// Longest varint accepted; a continuation bit on this byte is an error.
	localparam int unsigned VARINT_MAX_BYTES = 10;

	// Result kinds.
	localparam logic [1:0] KIND_FIELD = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_GROUP    = 3'd1;
	localparam logic [2:0] ST_UNKNOWN  = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_OVERLONG = 3'd4;

	// Wire types.
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_SGROUP  = 3'd3;
	localparam logic [2:0] WT_EGROUP  = 3'd4;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	// Everything one input word causes: an optional field record and an
	// optional trailing end or error record.
	typedef struct packed {
		logic        rec_v;
		logic        tail_v;
		logic [1:0]  tail_kind;
		logic [2:0]  tail_status;
		logic        tail_fnz;
		logic [28:0] fn;
		logic [2:0]  wt;
		logic [63:0] value;
		logic [31:0] offset;
		logic [63:0] end_len;
	} pwsp_entry_t;

endpackage

>>> src/pwsp_front.sv
`include "protobuf_wire_stream_parser_macros.svh"

module pwsp_front import pwsp_pkg::*; #(
	parameter int unsigned POS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	input  logic        full,
	output logic        push,
	output pwsp_entry_t entry
);

	localparam logic [2:0] PH_TAG     = 3'd0;
	localparam logic [2:0] PH_VARINT  = 3'd1;
	localparam logic [2:0] PH_FIXED   = 3'd2;
	localparam logic [2:0] PH_LENGTH  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0]          phase_q, phase_n;
	logic [63:0]         acc_q, acc_n;
	logic [3:0]          cnt_q, cnt_n;
	logic [28:0]         fn_q, fn_n;
	logic [2:0]          wt_q, wt_n;
	logic [31:0]         left_q, left_n;
	logic [POS_BITS-1:0] pos_q, pos_inc;
	logic                err_q;

	logic        accept;
	logic [6:0]  sh;
	logic [63:0] vshift, fshift, tag_word;
	logic [3:0]  cnt_inc, fcnt, fneed;
	logic        v_done, v_over;
	logic [2:0]  err_code;
	logic        rec_v;
	logic [63:0] rec_val;
	logic [31:0] rec_off;

	assign accept  = in_valid && !full;
	assign pos_inc = pos_q + 1'b1;

	// Byte lane arithmetic for varints and fixed-width values.
	always_comb begin
		sh       = 7'(cnt_q) * 7'd7;
		vshift   = {57'd0, in_byte[6:0]} << sh;
		cnt_inc  = cnt_q + 4'd1;
		v_done   = !in_byte[7];
		v_over   = in_byte[7] && (cnt_inc >= 4'(VARINT_MAX_BYTES));
		fshift   = {56'd0, in_byte} << {cnt_q[2:0], 3'b000};
		fcnt     = {1'b0, cnt_q[2:0]} + 4'd1;
		fneed    = (wt_q == WT_FIXED64) ? 4'd8 : 4'd4;
		tag_word = acc_q | vshift;
	end

	// Decode step: next state and the record this word completes.
	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		fn_n     = fn_q;
		wt_n     = wt_q;
		left_n   = left_q;
		err_code = ST_OK;
		rec_v    = 1'b0;
		rec_val  = acc_q;
		rec_off  = 32'd0;
		unique case (phase_q)
			PH_TAG: begin
				acc_n = tag_word;
				cnt_n = cnt_inc;
				if (v_over) begin
					err_code = ST_OVERLONG;
				end else if (v_done) begin
					fn_n  = tag_word[31:3];
					wt_n  = tag_word[2:0];
					acc_n = 64'd0;
					cnt_n = 4'd0;
					unique case (tag_word[2:0])
						WT_VARINT:              phase_n = PH_VARINT;
						WT_FIXED64, WT_FIXED32: phase_n = PH_FIXED;
						WT_LEN:                 phase_n = PH_LENGTH;
						WT_SGROUP, WT_EGROUP:   err_code = ST_GROUP;
						default:                err_code = ST_UNKNOWN;
					endcase
				end
			end
			PH_VARINT, PH_LENGTH: begin
				acc_n = tag_word;
				cnt_n = cnt_inc;
				if (v_over) begin
					err_code = ST_OVERLONG;
				end else if (v_done) begin
					rec_v   = 1'b1;
					rec_val = tag_word;
					phase_n = PH_TAG;
					if (phase_q == PH_LENGTH) begin
						rec_off = 32'(pos_inc);
						left_n  = (|tag_word[63:32]) ? 32'hFFFF_FFFF : tag_word[31:0];
						if (left_n != 32'd0) begin
							phase_n = PH_PAYLOAD;
						end
					end
					acc_n = 64'd0;
					cnt_n = 4'd0;
				end
			end
			PH_FIXED: begin
				acc_n = acc_q | fshift;
				cnt_n = fcnt;
				if (fcnt >= fneed) begin
					rec_v   = 1'b1;
					rec_val = acc_q | fshift;
					phase_n = PH_TAG;
					acc_n   = 64'd0;
					cnt_n   = 4'd0;
				end
			end
			PH_PAYLOAD: begin
				if (left_q != 32'd0) begin
					left_n = left_q - 32'd1;
				end
				if (left_n == 32'd0) begin
					phase_n = PH_TAG;
				end
			end
			default: begin
				phase_n = PH_TAG;
			end
		endcase
	end

	// Queue entry: the field record plus any end or error record.
	always_comb begin
		entry.rec_v       = rec_v;
		entry.fn          = fn_n;
		entry.wt          = wt_n;
		entry.value       = rec_val;
		entry.offset      = rec_off;
		entry.end_len     = 64'(pos_inc);
		entry.tail_v      = 1'b0;
		entry.tail_kind   = KIND_ERROR;
		entry.tail_status = ST_OK;
		entry.tail_fnz    = 1'b1;
		if (err_code != ST_OK) begin
			entry.tail_v      = 1'b1;
			entry.tail_status = err_code;
			entry.tail_fnz    = !((phase_n != PH_TAG) || (err_code == ST_GROUP) ||
				(err_code == ST_UNKNOWN));
		end else if (last_byte) begin
			entry.tail_v = 1'b1;
			if (phase_n == PH_TAG && cnt_n == 4'd0) begin
				entry.tail_kind = KIND_END;
			end else begin
				entry.tail_status = ST_TRUNC;
				entry.tail_fnz    = (phase_n == PH_TAG);
			end
		end
		push = accept && !err_q && (rec_v || entry.tail_v);
	end

	// Decode state. A marked word returns it to the reset state; an error holds it and drops words until then.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q   <= '0;
			cnt_q   <= '0;
			fn_q    <= '0;
			wt_q    <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_TAG;
				acc_q   <= '0;
				cnt_q   <= '0;
				fn_q    <= '0;
				wt_q    <= '0;
				left_q  <= '0;
				pos_q   <= '0;
				err_q   <= 1'b0;
			end else if (!err_q) begin
				if (err_code != ST_OK) begin
					err_q <= 1'b1;
				end else begin
					phase_q <= phase_n;
					acc_q   <= acc_n;
					cnt_q   <= cnt_n;
					fn_q    <= fn_n;
					wt_q    <= wt_n;
					left_q  <= left_n;
					pos_q   <= pos_inc;
				end
			end
		end
	end

	`PWSP_ASSERT_NOW(a_push_needs_accept, push, accept, "push without accepted word")

endmodule

>>> src/pwsp_queue.sv
`include "protobuf_wire_stream_parser_macros.svh"

module pwsp_queue import pwsp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pwsp_entry_t din,
	input  logic        pop,
	output pwsp_entry_t head,
	output logic        full,
	output logic        empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pwsp_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`PWSP_ASSERT_NOW(a_no_overflow, push, !full, "queue written while full")
	`PWSP_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")
	`PWSP_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after write")

endmodule

>>> src/pwsp_back.sv
`include "protobuf_wire_stream_parser_macros.svh"

module pwsp_back import pwsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pwsp_entry_t head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [28:0] fld_num,
	output logic [2:0]  wtype,
	output logic [63:0] value,
	output logic [31:0] payload_offset,
	output logic [2:0]  status,
	output logic        last_of_step
);

	logic        valid_q;
	logic        half_q;
	logic        load, emit, pick_rec;
	logic [1:0]  kind_q;
	logic [28:0] fn_q;
	logic [2:0]  wt_q;
	logic [63:0] value_q;
	logic [31:0] off_q;
	logic [2:0]  status_q;
	logic        last_q;

	assign load     = !valid_q || !out_stall;
	assign emit     = load && !empty;
	assign pick_rec = head.rec_v && !half_q;
	assign pop      = emit && (!pick_rec || !head.tail_v);

	// Output register valid and the record-or-tail selector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= emit;
			end
			if (emit) begin
				half_q <= pick_rec && head.tail_v;
			end
		end
	end

	// Output payload: the field record first, then the end or error record.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (pick_rec) begin
				kind_q   <= KIND_FIELD;
				fn_q     <= head.fn;
				wt_q     <= head.wt;
				value_q  <= head.value;
				off_q    <= head.offset;
				status_q <= ST_OK;
				last_q   <= !head.tail_v;
			end else begin
				kind_q   <= head.tail_kind;
				fn_q     <= head.tail_fnz ? 29'd0 : head.fn;
				wt_q     <= head.tail_fnz ? 3'd0 : head.wt;
				value_q  <= (head.tail_kind == KIND_END) ? head.end_len : 64'd0;
				off_q    <= 32'd0;
				status_q <= head.tail_status;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid      = valid_q;
	assign kind           = kind_q;
	assign fld_num        = fn_q;
	assign wtype          = wt_q;
	assign value          = value_q;
	assign payload_offset = off_q;
	assign status         = status_q;
	assign last_of_step   = last_q;

	`PWSP_ASSERT_NOW(a_half_has_tail, half_q, !empty && head.rec_v && head.tail_v,
		"second record selected without a pending tail")
	`PWSP_ASSERT_NOW(a_pop_on_emit, pop, emit, "entry dropped without output")

endmodule

>>> src/protobuf_wire_stream_parser.sv
// Channel | Direction | Handshake            | Word contents
// input   | in        | in_valid / in_stall   | in_byte, last_byte
// output  | out       | out_valid / out_stall | kind, fld_num, wtype, value,
//         |           |                       | payload_offset, status, last_of_step
//
// One byte is accepted per cycle while the result queue has room.
// A result passes through the queue and then the output register; the output register
// sends one result per cycle unless stalled, so a byte with two results sends two words.
// Reset clears the decode state, the queue and the output register; no clearing pass.
// Output stalls back up into the queue (QUEUE_DEPTH entries) and then stall the input.
module protobuf_wire_stream_parser import pwsp_pkg::*; #(
	parameter int unsigned POS_BITS    = 32,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [28:0] fld_num,
	output logic [2:0]  wtype,
	output logic [63:0] value,
	output logic [31:0] payload_offset,
	output logic [2:0]  status,
	output logic        last_of_step
);

	pwsp_entry_t q_din, q_head;
	logic        q_push, q_pop, q_full, q_empty;

	assign in_stall = q_full;

	// Byte decoder.
	pwsp_front #(
		.POS_BITS(POS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.last_byte(last_byte),
		.full     (q_full),
		.push     (q_push),
		.entry    (q_din)
	);

	// Result queue between decoder and output.
	pwsp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.pop   (q_pop),
		.head  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	// Record serializer and output register.
	pwsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.fld_num       (fld_num),
		.wtype         (wtype),
		.value         (value),
		.payload_offset(payload_offset),
		.status        (status),
		.last_of_step  (last_of_step)
	);

endmodule

>>> bench/tb_protobuf_wire_stream_parser.sv
module tb_protobuf_wire_stream_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import pwsp_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;

	// Wire types with no meaning in the format.
	localparam logic [2:0] WT_RESERVED6 = 3'd6;
	localparam logic [2:0] WT_RESERVED7 = 3'd7;

	typedef enum logic [2:0] {
		DEC_TAG, DEC_VARINT, DEC_FIXED, DEC_LENGTH, DEC_PAYLOAD
	} dec_phase_t;

	typedef enum logic [1:0] {VB_MORE, VB_DONE, VB_OVERLONG} varint_step_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [28:0] fnum;
		logic [2:0]  wtype;
		logic [63:0] val;
		logic [31:0] offset;
		logic [2:0]  stat;
		logic        tail;
	} parsed_record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [28:0] fld_num;
	logic [2:0]  wtype;
	logic [63:0] value;
	logic [31:0] payload_offset;
	logic [2:0]  status;
	logic        last_of_step;

	// Decoder state of the predictor.
	dec_phase_t  dphase;
	logic [63:0] acc;
	logic [3:0]  cnt;
	logic [28:0] fnum;
	logic [2:0]  wtyp;
	logic [31:0] skip_left;
	logic [31:0] pos;
	logic        dropping;

	parsed_record_t pending_records[$];
	logic [7:0]     msg_q[$];
	int             result_errors = 0;
	int             bytes_sent = 0;
	int             send_gap_pct = 0;
	int             recv_stall_pct = 0;

	protobuf_wire_stream_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.fld_num(fld_num),
		.wtype(wtype),
		.value(value),
		.payload_offset(payload_offset),
		.status(status),
		.last_of_step(last_of_step)
	);

	always #HALF_PERIOD clk = ~clk;

	// The receiver stalls at random at the current rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Returns the decoder to the start of a message.
	function automatic void clear_decoder();
		dphase = DEC_TAG;
		acc = '0;
		cnt = '0;
		fnum = '0;
		wtyp = '0;
		skip_left = '0;
		pos = '0;
		dropping = 1'b0;
	endfunction

	function automatic parsed_record_t make_record(logic [1:0] k, logic [28:0] fn,
			logic [2:0] wt, logic [63:0] v, logic [31:0] off, logic [2:0] st);
		parsed_record_t r;
		r.kind = k;
		r.fnum = fn;
		r.wtype = wt;
		r.val = v;
		r.offset = off;
		r.stat = st;
		r.tail = 1'b0;
		return r;
	endfunction

	// Adds one byte to the varint being collected; bits past 64 are lost.
	function automatic varint_step_t absorb_varint_byte(logic [7:0] b);
		int shift;
		shift = 7 * cnt;
		if (shift < 64) begin
			acc = acc | ({57'd0, b[6:0]} << shift);
		end
		cnt = cnt + 4'd1;
		if (b[7]) begin
			return (cnt >= VARINT_MAX_BYTES) ? VB_OVERLONG : VB_MORE;
		end
		return VB_DONE;
	endfunction

	// Works out the records that one accepted byte causes and queues them.
	task automatic decode_byte(input logic [7:0] b, input logic last);
		parsed_record_t step_q[$];
		varint_step_t   vs;
		logic [2:0]     err;
		logic           tag_known;
		logic [31:0]    off;
		logic [31:0]    msg_len;
		logic [2:0]     slot;
		int             need;
		int             i;
		if (dropping) begin
			if (last) begin
				clear_decoder();
			end
			return;
		end
		err = ST_OK;
		case (dphase)
			DEC_TAG: begin
				vs = absorb_varint_byte(b);
				if (vs == VB_OVERLONG) begin
					err = ST_OVERLONG;
				end else if (vs == VB_DONE) begin
					fnum = acc[31:3];
					wtyp = acc[2:0];
					acc = '0;
					cnt = '0;
					case (wtyp)
						WT_VARINT: dphase = DEC_VARINT;
						WT_FIXED64, WT_FIXED32: dphase = DEC_FIXED;
						WT_LEN: dphase = DEC_LENGTH;
						WT_SGROUP, WT_EGROUP: err = ST_GROUP;
						default: err = ST_UNKNOWN;
					endcase
				end
			end
			DEC_VARINT, DEC_LENGTH: begin
				vs = absorb_varint_byte(b);
				if (vs == VB_OVERLONG) begin
					err = ST_OVERLONG;
				end else if (vs == VB_DONE) begin
					off = '0;
					if (dphase == DEC_LENGTH) begin
						off = pos + 32'd1;
						skip_left = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
					end
					step_q = {step_q, make_record(KIND_FIELD, fnum, wtyp, acc, off, ST_OK)};
					dphase = (dphase == DEC_LENGTH && skip_left != 0) ? DEC_PAYLOAD : DEC_TAG;
					acc = '0;
					cnt = '0;
				end
			end
			DEC_FIXED: begin
				need = (wtyp == WT_FIXED64) ? 8 : 4;
				slot = cnt[2:0];
				acc = acc | ({56'd0, b} << (8 * slot));
				cnt = {1'b0, slot} + 4'd1;
				if (cnt >= need) begin
					step_q = {step_q, make_record(KIND_FIELD, fnum, wtyp, acc, '0, ST_OK)};
					dphase = DEC_TAG;
					acc = '0;
					cnt = '0;
				end
			end
			default: begin
				if (skip_left != 0) begin
					skip_left = skip_left - 32'd1;
				end
				if (skip_left == 0) begin
					dphase = DEC_TAG;
				end
			end
		endcase

		if (err != ST_OK) begin
			// The first error of a message; the rest of it is dropped.
			tag_known = (dphase != DEC_TAG) || err == ST_GROUP || err == ST_UNKNOWN;
			step_q = {step_q, make_record(KIND_ERROR, tag_known ? fnum : 29'd0,
				tag_known ? wtyp : 3'd0, '0, '0, err)};
			if (last) begin
				clear_decoder();
			end else begin
				dropping = 1'b1;
			end
		end else if (last) begin
			// A message ends cleanly only between fields.
			if (dphase == DEC_TAG && cnt == 0) begin
				msg_len = pos + 32'd1;
				step_q = {step_q, make_record(KIND_END, '0, '0, {32'd0, msg_len}, '0, ST_OK)};
			end else begin
				tag_known = (dphase != DEC_TAG);
				step_q = {step_q, make_record(KIND_ERROR, tag_known ? fnum : 29'd0,
					tag_known ? wtyp : 3'd0, '0, '0, ST_TRUNC)};
			end
			clear_decoder();
		end else begin
			pos = pos + 32'd1;
		end

		if (step_q.size() > 0) begin
			step_q[step_q.size() - 1].tail = 1'b1;
		end
		for (i = 0; i < step_q.size(); i++) begin
			pending_records = {pending_records, step_q[i]};
		end
	endtask

	function automatic void report_mismatch(string what, parsed_record_t want,
			parsed_record_t got);
		if (result_errors < REPORT_LIMIT) begin
			$display("%0t %s: expected kind=%0d fn=%0d wt=%0d value=%h off=%0d st=%0d last=%b",
				$realtime, what, want.kind, want.fnum, want.wtype, want.val, want.offset,
				want.stat, want.tail);
			$display("    got kind=%0d fn=%0d wt=%0d value=%h off=%0d st=%0d last=%b",
				got.kind, got.fnum, got.wtype, got.val, got.offset, got.stat, got.tail);
		end
		result_errors++;
	endfunction

	// Each accepted result word is checked against the oldest expected record.
	always @(posedge clk) begin
		parsed_record_t got;
		parsed_record_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.fnum = fld_num;
			got.wtype = wtype;
			got.val = value;
			got.offset = payload_offset;
			got.stat = status;
			got.tail = last_of_step;
			if (pending_records.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_records.pop_front();
				if (got.kind !== want.kind || got.fnum !== want.fnum
						|| got.wtype !== want.wtype || got.val !== want.val
						|| got.offset !== want.offset || got.stat !== want.stat
						|| got.tail !== want.tail) begin
					report_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

	// Offers one byte, with random gaps first, and predicts it once accepted.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		decode_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_message();
		int i;
		for (i = 0; i < msg_q.size(); i++) begin
			send_byte(msg_q[i], i == msg_q.size() - 1);
		end
	endtask

	// Holds the input off until every expected record has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_records.size() != 0);
	endtask

	// Appends a varint, optionally padded with extra zero groups.
	function automatic void put_varint(logic [63:0] v, int pad);
		int          groups;
		int          i;
		logic [63:0] tmp;
		logic [7:0]  b;
		groups = 1;
		while (groups < 10 && (v >> (7 * groups)) != 0) begin
			groups++;
		end
		groups = groups + pad;
		if (groups > 10) begin
			groups = 10;
		end
		for (i = 0; i < groups; i++) begin
			tmp = v >> (7 * i);
			b = {1'b0, tmp[6:0]};
			// The tenth group carries bits past 64 that the decoder drops.
			if (i == 9 && $urandom_range(1) == 1) begin
				b[6:1] = 6'($urandom);
			end
			if (i < groups - 1) begin
				b[7] = 1'b1;
			end
			msg_q = {msg_q, b};
		end
	endfunction

	// A varint that still continues on its last allowed byte.
	function automatic void put_overlong();
		int i;
		for (i = 0; i < VARINT_MAX_BYTES; i++) begin
			msg_q = {msg_q, {1'b1, 7'($urandom)}};
		end
	endfunction

	function automatic int rand_pad();
		return ($urandom_range(7) == 0) ? $urandom_range(1, 4) : 0;
	endfunction

	// Builds one message: mostly well-formed fields, some errors and noise.
	function automatic void build_message();
		int          fields;
		int          i;
		int          len;
		int          cut;
		logic [63:0] fn_wide;
		logic [63:0] v;
		logic [2:0]  wt;
		logic        stop;
		msg_q.delete();
		if ($urandom_range(99) < 8) begin
			len = $urandom_range(1, 8);
			repeat (len) msg_q = {msg_q, 8'($urandom)};
			return;
		end
		fields = $urandom_range(1, 4);
		stop = 1'b0;
		for (i = 0; i < fields && !stop; i++) begin
			case ($urandom_range(9))
				0: fn_wide = '0;
				1, 2, 3, 4, 5: fn_wide = $urandom_range(1, 15);
				6, 7: fn_wide = $urandom_range(16, 32'h1FFF_FFFF);
				default: fn_wide = {$urandom, $urandom} >> $urandom_range(3, 34);
			endcase
			if ($urandom_range(9) != 0) begin
				case ($urandom_range(3))
					0: wt = WT_VARINT;
					1: wt = WT_FIXED64;
					2: wt = WT_LEN;
					default: wt = WT_FIXED32;
				endcase
			end else begin
				case ($urandom_range(3))
					0: wt = WT_SGROUP;
					1: wt = WT_EGROUP;
					2: wt = WT_RESERVED6;
					default: wt = WT_RESERVED7;
				endcase
			end
			if ($urandom_range(99) < 3) begin
				put_overlong();
				stop = 1'b1;
			end else begin
				put_varint({fn_wide[60:0], wt}, rand_pad());
				case (wt)
					WT_VARINT: begin
						if ($urandom_range(99) < 4) begin
							put_overlong();
							stop = 1'b1;
						end else begin
							v = {$urandom, $urandom} >> $urandom_range(0, 63);
							if ($urandom_range(7) == 0) begin
								v = '1;
							end
							put_varint(v, rand_pad());
						end
					end
					WT_FIXED64: repeat (8) msg_q = {msg_q, 8'($urandom)};
					WT_FIXED32: repeat (4) msg_q = {msg_q, 8'($urandom)};
					WT_LEN: begin
						if ($urandom_range(99) < 4) begin
							put_overlong();
							stop = 1'b1;
						end else if ($urandom_range(19) == 0) begin
							// Length past 32 bits; the message ends inside the payload.
							put_varint({$urandom | 32'd1, $urandom}, 0);
							repeat ($urandom_range(0, 3)) msg_q = {msg_q, 8'($urandom)};
							stop = 1'b1;
						end else begin
							len = $urandom_range(0, 6);
							put_varint(len, rand_pad());
							repeat (len) msg_q = {msg_q, 8'($urandom)};
						end
					end
					default: begin
						repeat ($urandom_range(0, 3)) msg_q = {msg_q, 8'($urandom)};
						stop = 1'b1;
					end
				endcase
			end
			if (stop) begin
				repeat ($urandom_range(0, 3)) msg_q = {msg_q, 8'($urandom)};
			end
		end
		// Some messages are cut short at a random byte.
		if ($urandom_range(99) < 12 && msg_q.size() > 1) begin
			cut = $urandom_range(1, msg_q.size() - 1);
			while (msg_q.size() > cut) begin
				msg_q.delete(msg_q.size() - 1);
			end
		end
	endfunction

	// Well-formed fields of every wire type, with field number zero and an empty payload.
	task automatic test_field_kinds();
		msg_q = '{8'h00, 8'h00, 8'h12, 8'h00, 8'h1D, 8'h78, 8'h56, 8'h34};
		msg_q = {msg_q, 8'h12};
		msg_q = {msg_q, 8'h09};
		repeat (8) msg_q = {msg_q, 8'hFF};
		send_message();
	endtask

	// Group and unknown types, truncation in a tag, a varint and a payload, an overlong tag, dropped bytes.
	task automatic test_error_cases();
		msg_q = '{8'h0B};
		send_message();
		msg_q = '{8'h14};
		send_message();
		msg_q = '{8'h1E};
		send_message();
		msg_q = '{8'h27, 8'hAA, 8'h55};
		send_message();
		msg_q = '{8'h0A, 8'h05, 8'h01};
		send_message();
		msg_q = '{8'h80};
		send_message();
		msg_q = '{8'h08, 8'h96};
		send_message();
		msg_q.delete();
		put_overlong();
		send_message();
	endtask

	task automatic test_random_messages(input int budget);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			build_message();
			send_message();
		end
	endtask

	initial begin
		clear_decoder();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 32;
		recv_stall_pct = 80;
		test_field_kinds();
		test_error_cases();
		wait_for_results();
		test_random_messages(420);
		wait_for_results();

		send_gap_pct = 80;
		recv_stall_pct = 32;
		test_random_messages(420);
		wait_for_results();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_messages(410);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (pending_records.size() != 0) begin
			report_mismatch("missing result", pending_records[0], '0);
		end
		if (result_errors == 0 && pending_records.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
